@@ hdl/eabv_pkg.sv @@
// Package: constants, types and CORDIC arctangent table for the basis-vector block.
package eabv_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 14;
    localparam int CORDIC_STEPS   = 30;
    localparam int QW             = 33;   // signed Q30 working width, holds +/-2^31
    localparam logic signed [QW-1:0] GAIN_INV = 33'sd652032874;
    localparam logic signed [QW-1:0] Q30_ONE  = 33'sd1073741824;

    typedef logic signed [QW-1:0] q30_t;

    typedef struct packed {
        q30_t sn;
        q30_t cs;
    } sincos_t;

    function automatic logic [31:0] atan_lut(input int i);
        logic [31:0] t;
        case (i)
            0: t = 32'h20000000;  1: t = 32'h12E4051E;  2: t = 32'h09FB385B;
            3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
            6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
            9: t = 32'h00145F2F; 10: t = 32'h000A2F98; 11: t = 32'h000517CC;
            12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2FA;
            15: t = 32'h0000517D; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
            18: t = 32'h00000A30; 19: t = 32'h00000518; 20: t = 32'h0000028C;
            21: t = 32'h00000146; 22: t = 32'h000000A3; 23: t = 32'h00000051;
            24: t = 32'h00000029; 25: t = 32'h00000014; 26: t = 32'h0000000A;
            27: t = 32'h00000005; 28: t = 32'h00000003; 29: t = 32'h00000001;
            default: t = 32'h0;
        endcase
        return t;
    endfunction

    // (a*b + 2^29) >>> 30 with floor shift
    function automatic q30_t mul30(input q30_t a, input q30_t b);
        logic signed [2*QW-1:0] p;
        p = a * b + (66'sd1 <<< 29);
        return q30_t'(p >>> 30);
    endfunction

    function automatic q30_t clamp30(input q30_t v);
        q30_t r;
        if (v > Q30_ONE)       r = Q30_ONE;
        else if (v < -Q30_ONE) r = -Q30_ONE;
        else                   r = v;
        return r;
    endfunction

endpackage

@@ hdl/euler_angles_to_basis_vectors.sv @@
// Top level: Euler binary angles to forward, right and up Q1.FRAC unit vectors.
//
// Input channel (s_): one beat carries pitch, yaw and roll as binary angles,
// 2^ANGLE_BITS per full turn; angles wrap. Output channel (m_): one beat per
// input beat, nine signed components packed 16 bits apiece (FRAC_BITS+2).
// Sine/cosine per angle: three parallel pipelined CORDICs in Q30 (a load stage,
// 30 micro-rotation stages, a quadrant fold), then two product stages, a sum
// stage, a round stage and a saturating output register.
// Stages: 32 CORDIC stages, 4 product/sum/round stages, 1 output register.
// Throughput: one beat per cycle while m_tready is high; every stage is one register deep.
// Stall: a stage advances when it is empty or the stage after it advances,
// so the pipe compresses bubbles under m_tready low and s_tready drops only
// when every stage holds a beat. Nothing is dropped or repeated.
// Reset (aresetn low, synchronous): all valid bits clear; data regs hold.
// No configuration; the block keeps no state between beats.
module euler_angles_to_basis_vectors #(
    parameter int ANGLE_BITS = eabv_pkg::ANGLE_BITS_DEF,
    parameter int FRAC_BITS  = eabv_pkg::FRAC_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // pitch_angle, yaw_angle, roll_angle from bit 0 up, zero fill to bytes
    input  logic [((3*ANGLE_BITS+7)/8)*8-1:0] s_tdata,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // forward_x,y,z, right_x,y,z, up_x,y,z from bit 0 up, zero fill to bytes
    output logic [((9*(FRAC_BITS+2)+7)/8)*8-1:0] m_tdata
);
    import eabv_pkg::*;

    localparam int OW    = FRAC_BITS + 2;
    localparam int NC    = CORDIC_STEPS + 2;  // CORDIC stages
    localparam int NST   = NC + 5;            // total stages
    localparam int SH    = 30 - FRAC_BITS;
    localparam int OUTW  = ((9*OW+7)/8)*8;

    logic [NST-1:0] vld_reg;
    logic [NST-1:0] adv;

    // stage k advances if empty or downstream advances; last is the output reg
    always_comb begin
        adv[NST-1] = !vld_reg[NST-1] || m_tready;
        for (int k = NST-2; k >= 0; k--) adv[k] = !vld_reg[k] || adv[k+1];
    end

    assign s_tready = adv[0];
    assign m_tvalid = vld_reg[NST-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (adv[0]) vld_reg[0] <= s_tvalid;
            for (int k = 1; k < NST; k++) if (adv[k]) vld_reg[k] <= vld_reg[k-1];
        end
    end

    sincos_t p_sc, y_sc, r_sc;
    logic [NC-1:0] cen;
    assign cen = adv[NC-1:0];

    eabv_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_pitch (
        .aclk(aclk), .angle(s_tdata[ANGLE_BITS-1:0]), .en(cen), .result(p_sc));
    eabv_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_yaw (
        .aclk(aclk), .angle(s_tdata[2*ANGLE_BITS-1:ANGLE_BITS]), .en(cen), .result(y_sc));
    eabv_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_roll (
        .aclk(aclk), .angle(s_tdata[3*ANGLE_BITS-1:2*ANGLE_BITS]), .en(cen),
        .result(r_sc));

    // stage A: first products, pass-through of trig values
    q30_t srsp_reg, crsp_reg, cpcy_reg, cpsy_reg, nsp_reg, srcp_reg, crcp_reg;
    q30_t crsy_reg, crcy_reg, srsy_reg, srcy_reg, a_cy_reg, a_sy_reg;
    always_ff @(posedge aclk) begin
        if (adv[NC]) begin
            srsp_reg <= mul30(r_sc.sn, p_sc.sn);
            crsp_reg <= mul30(r_sc.cs, p_sc.sn);
            cpcy_reg <= mul30(p_sc.cs, y_sc.cs);
            cpsy_reg <= mul30(p_sc.cs, y_sc.sn);
            nsp_reg  <= -p_sc.sn;
            srcp_reg <= mul30(r_sc.sn, p_sc.cs);
            crcp_reg <= mul30(r_sc.cs, p_sc.cs);
            crsy_reg <= mul30(r_sc.cs, y_sc.sn);
            crcy_reg <= mul30(r_sc.cs, y_sc.cs);
            srsy_reg <= mul30(r_sc.sn, y_sc.sn);
            srcy_reg <= mul30(r_sc.sn, y_sc.cs);
            a_cy_reg <= y_sc.cs;
            a_sy_reg <= y_sc.sn;
        end
    end

    // stage B: second products, pass-through of first products
    q30_t b_v_reg [9];
    q30_t b_t_reg [4];
    always_ff @(posedge aclk) begin
        if (adv[NC+1]) begin
            b_v_reg[0] <= cpcy_reg;
            b_v_reg[1] <= cpsy_reg;
            b_v_reg[2] <= nsp_reg;
            b_v_reg[3] <= crsy_reg;
            b_v_reg[4] <= crcy_reg;
            b_v_reg[5] <= -srcp_reg;
            b_v_reg[6] <= srsy_reg;
            b_v_reg[7] <= srcy_reg;
            b_v_reg[8] <= crcp_reg;
            b_t_reg[0] <= mul30(srsp_reg, a_cy_reg);
            b_t_reg[1] <= mul30(srsp_reg, a_sy_reg);
            b_t_reg[2] <= mul30(crsp_reg, a_cy_reg);
            b_t_reg[3] <= mul30(crsp_reg, a_sy_reg);
        end
    end

    // stage C: sums
    q30_t c_v_reg [9];
    always_ff @(posedge aclk) begin
        if (adv[NC+2]) begin
            c_v_reg[0] <= b_v_reg[0];
            c_v_reg[1] <= b_v_reg[1];
            c_v_reg[2] <= b_v_reg[2];
            c_v_reg[3] <= b_v_reg[3] - b_t_reg[0];
            c_v_reg[4] <= -b_t_reg[1] - b_v_reg[4];
            c_v_reg[5] <= b_v_reg[5];
            c_v_reg[6] <= b_t_reg[2] + b_v_reg[6];
            c_v_reg[7] <= b_t_reg[3] - b_v_reg[7];
            c_v_reg[8] <= b_v_reg[8];
        end
    end

    // stage D: round to output step
    localparam logic signed [QW:0] LIM = (QW+1)'(1) <<< FRAC_BITS;
    logic signed [QW:0] d_v_reg [9];
    always_ff @(posedge aclk) begin
        if (adv[NC+3]) begin
            for (int k = 0; k < 9; k++) begin
                if (SH > 0)
                    d_v_reg[k] <= ((QW+1)'(c_v_reg[k]) + ((QW+1)'(1) <<< (SH-1))) >>> SH;
                else
                    d_v_reg[k] <= (QW+1)'(c_v_reg[k]);
            end
        end
    end

    // stage E: saturate, output register
    logic [OUTW-1:0] out_next;
    logic [OUTW-1:0] out_reg;
    always_comb begin
        out_next = '0;
        for (int k = 0; k < 9; k++) begin
            if (d_v_reg[k] > LIM)       out_next[k*OW +: OW] = OW'(LIM);
            else if (d_v_reg[k] < -LIM) out_next[k*OW +: OW] = OW'(-LIM);
            else                        out_next[k*OW +: OW] = OW'(d_v_reg[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[NC+4]) begin
            out_reg <= out_next;
        end
    end

    assign m_tdata = out_reg;
endmodule

@@ hdl/eabv_cordic.sv @@
// Pipelined rotation-mode CORDIC: one angle in per cycle while its stages advance, sine and cosine in Q30 out.
module eabv_cordic #(
    parameter int ANGLE_BITS = eabv_pkg::ANGLE_BITS_DEF
) (
    input  logic                   aclk,
    input  logic [ANGLE_BITS-1:0]  angle,
    input  logic [eabv_pkg::CORDIC_STEPS+1:0] en,   // per-stage advance
    output eabv_pkg::sincos_t      result
);
    import eabv_pkg::*;

    localparam int NS = CORDIC_STEPS;

    q30_t       x_reg [NS+1];
    q30_t       y_reg [NS+1];
    q30_t       z_reg [NS+1];
    logic [1:0] q_reg [NS+1];
    sincos_t    res_reg;

    logic [31:0] a32;
    logic [1:0]  q0;
    logic [31:0] r0;

    always_comb begin
        a32 = {angle, {(32-ANGLE_BITS){1'b0}}};
        q0  = 2'((a32 + 32'h20000000) >> 30);
        r0  = a32 - {q0, 30'b0};
    end

    // stage 0 loads the reduced angle, stages 1..NS do one micro-rotation each
    always_ff @(posedge aclk) begin
        if (en[0]) begin
            x_reg[0] <= GAIN_INV;
            y_reg[0] <= '0;
            z_reg[0] <= q30_t'($signed(r0));
            q_reg[0] <= q0;
        end
        for (int i = 0; i < NS; i++) begin
            if (en[i+1]) begin
                q_reg[i+1] <= q_reg[i];
                if (!z_reg[i][QW-1]) begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - q30_t'(atan_lut(i));
                end else begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + q30_t'(atan_lut(i));
                end
            end
        end
    end

    q30_t c_w, s_w;
    assign c_w = clamp30(x_reg[NS]);
    assign s_w = clamp30(y_reg[NS]);

    always_ff @(posedge aclk) begin
        if (en[NS+1]) begin
            case (q_reg[NS])
                2'd0:    begin res_reg.cs <= c_w;  res_reg.sn <= s_w;  end
                2'd1:    begin res_reg.cs <= -s_w; res_reg.sn <= c_w;  end
                2'd2:    begin res_reg.cs <= -c_w; res_reg.sn <= -s_w; end
                default: begin res_reg.cs <= s_w;  res_reg.sn <= -c_w; end
            endcase
        end
    end

    assign result = res_reg;
endmodule

@@ hdl/eabv_checker.sv @@
// Port-level checker for the basis-vector block, bound to the top level.
module eabv_checker #(
    parameter int OUTW = 144,
    parameter int OW   = 16,
    parameter int FRAC_BITS = 14
) (
    input logic            aclk,
    input logic            aresetn,
    input logic            s_tready,
    input logic            m_tvalid,
    input logic            m_tready,
    input logic [OUTW-1:0] m_tdata
);
    // no output beat right after reset
    a_rst_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("m_tvalid after reset");
    // stalled output beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat changed under stall");
    // input always ready when output side drains freely
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready && $past(m_tready) |-> s_tready)
        else $error("s_tready low while output drains");
    // forward_z stays in range
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[3*OW-1:2*OW]) <= (1 <<< FRAC_BITS)) &&
                     ($signed(m_tdata[3*OW-1:2*OW]) >= -(1 <<< FRAC_BITS)))
        else $error("forward_z out of range");
endmodule

bind euler_angles_to_basis_vectors eabv_checker #(
    .OUTW(((9*(FRAC_BITS+2)+7)/8)*8), .OW(FRAC_BITS+2), .FRAC_BITS(FRAC_BITS)
) u_eabv_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
